>>> src/epcg_pkg.sv
`default_nettype none
package epcg_pkg;

    // Default sieve depth, one entry per coefficient index.
    localparam int unsigned MAX_N_DEF = 4096;

    // Widths fixed by the item fields.
    localparam int unsigned IDX_W   = 12;
    localparam int unsigned TRACE_W = 9;
    localparam int unsigned COEF_W  = 32;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned PROD_W  = 64;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd1;
    localparam logic [STAT_W-1:0] STAT_REJ = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_CLASSIFY,
        ST_SQUARE,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FACT_RD,
        ST_FACT_CHK,
        ST_POWER_INIT,
        ST_PW_A,
        ST_PW_B,
        ST_PW_C,
        ST_FINAL_A,
        ST_FINAL_B
    } epcg_state_t;

    // True when a 64-bit signed value lies in the signed 32-bit range.
    function automatic logic fits32(input logic signed [PROD_W-1:0] v);
        fits32 = (v[PROD_W-1:COEF_W-1] == '0) || (v[PROD_W-1:COEF_W-1] == '1);
    endfunction

endpackage
`default_nettype wire

>>> src/epcg_mul.sv
`default_nettype none
module epcg_mul
    import epcg_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic signed [COEF_W-1:0] op_a,
    input  wire logic signed [COEF_W-1:0] op_b,
    output logic signed [PROD_W-1:0]      prod
);

    // Shared signed multiplier with a registered product.
    always_ff @(posedge aclk) begin
        prod <= op_a * op_b;
    end

endmodule
`default_nettype wire

>>> src/epcg_ram.sv
`default_nettype none
module epcg_ram
    import epcg_pkg::*;
#(
    parameter int unsigned AW = 12,
    parameter int unsigned DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [DW-1:0]      rdata
);

    logic [DW-1:0] mem [2**AW];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> src/euler_product_coefficient_generator_unit.sv
// A rejected index or one after a sticky overflow gives its beat in the cycle after it is taken.
// A composite index strips its smallest prime p (power e) via the sieve, forms the p^e term (a_p
// recurrence if good, plain trace power if bad) and scales it by the stored coefficient of the rest.
// A new prime p first marks its multiples from p*p up to MAX_N-1, a read and a write each on the
// one sieve port. One index is in flight at a time; a new index is taken once the previous result
// is gone. Reset (aresetn low, synchronous) starts a clearing pass over every sieve entry,
// during which no index is accepted; configuration writes are taken whenever reset is released.
`default_nettype none
module euler_product_coefficient_generator_unit
    import epcg_pkg::*;
#(
    parameter int unsigned MAX_N = MAX_N_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [IDX_W-1:0]          cfg_last_index,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [IDX_W-1:0]          s_index,
    input  wire logic signed [TRACE_W-1:0] s_trace_value,
    input  wire logic                      s_bad_prime,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [IDX_W-1:0]               m_out_index,
    output logic signed [COEF_W-1:0]       m_coefficient,
    output logic [STAT_W-1:0]              m_status
);

    localparam int unsigned AW = $clog2(MAX_N);
    localparam int unsigned EW = $clog2(AW + 1);
    localparam int unsigned SW = 2 * AW;
    localparam int unsigned TW = TRACE_W + 1;

    epcg_state_t state_reg, state_next;

    logic [IDX_W-1:0]         last_index_reg, last_index_next;
    logic [IDX_W-1:0]         expected_reg, expected_next;
    logic                     overflow_reg, overflow_next;
    logic [AW-1:0]            clr_reg, clr_next;
    logic                     out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]         out_index_reg, out_index_next;
    logic signed [COEF_W-1:0] out_coef_reg, out_coef_next;
    logic [STAT_W-1:0]        out_status_reg, out_status_next;

    logic [AW-1:0]              n_reg, n_next;
    logic signed [TRACE_W-1:0]  ap_reg, ap_next;
    logic                       bad_in_reg, bad_in_next;
    logic [AW-1:0]              p_reg, p_next;
    logic [AW-1:0]              rest_reg, rest_next;
    logic [EW-1:0]              e_reg, e_next;
    logic [AW:0]                m_reg, m_next;
    logic [AW-1:0]              k_reg, k_next;
    logic signed [TRACE_W-1:0]  tp_reg, tp_next;
    logic                       bad_reg, bad_next;
    logic signed [COEF_W-1:0]   cur_reg, cur_next;
    logic signed [COEF_W-1:0]   prev_reg, prev_next;
    logic signed [PROD_W-1:0]   t1_reg, t1_next;

    // Memory ports.
    logic               sv_we;
    logic [AW-1:0]      sv_waddr, sv_raddr;
    logic [SW-1:0]      sv_wdata, sv_rdata;
    logic               tr_we;
    logic [TW-1:0]      tr_rdata;
    logic               cf_we;
    logic [COEF_W-1:0]  cf_rdata;

    logic signed [COEF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;

    logic [AW-1:0]            sf_rd, q_rd;
    logic signed [COEF_W-1:0] rest_coef;
    logic signed [PROD_W-1:0] diff;
    logic [AW:0]              m_step;
    logic                     reject;

    assign sf_rd     = sv_rdata[SW-1:AW];
    assign q_rd      = sv_rdata[AW-1:0];
    assign rest_coef = (rest_reg == AW'(1)) ? COEF_W'(1) : $signed(cf_rdata);
    assign diff      = t1_reg - prod;
    assign m_step    = m_reg + (AW+1)'(n_reg);
    assign reject    = (s_index != expected_reg) || (s_index > last_index_reg) ||
                       (s_index < IDX_W'(2)) || (32'(s_index) >= 32'(MAX_N));

    assign cfg_ready     = aresetn;
    assign s_ready       = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_valid       = out_valid_reg;
    assign m_out_index   = out_index_reg;
    assign m_coefficient = out_coef_reg;
    assign m_status      = out_status_reg;

    // Sieve words hold the smallest prime factor and the quotient by it.
    epcg_ram #(.AW(AW), .DW(SW)) u_sieve (
        .aclk (aclk), .we (sv_we), .waddr (sv_waddr), .wdata (sv_wdata),
        .raddr (sv_raddr), .rdata (sv_rdata)
    );

    // Trace and bad-reduction flag of each prime.
    epcg_ram #(.AW(AW), .DW(TW)) u_trace (
        .aclk (aclk), .we (tr_we), .waddr (n_reg), .wdata ({bad_in_reg, ap_reg}),
        .raddr (p_reg), .rdata (tr_rdata)
    );

    // Coefficients emitted so far.
    epcg_ram #(.AW(AW), .DW(COEF_W)) u_coef (
        .aclk (aclk), .we (cf_we), .waddr (n_reg), .wdata (prod[COEF_W-1:0]),
        .raddr (rest_reg), .rdata (cf_rdata)
    );

    epcg_mul u_mul (
        .aclk (aclk), .op_a (mul_a), .op_b (mul_b), .prod (prod)
    );

    // Sequencer: next state, datapath updates and memory controls.
    always_comb begin
        state_next      = state_reg;
        last_index_next = last_index_reg;
        expected_next   = expected_reg;
        overflow_next   = overflow_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        out_index_next  = out_index_reg;
        out_coef_next   = out_coef_reg;
        out_status_next = out_status_reg;
        n_next          = n_reg;
        ap_next         = ap_reg;
        bad_in_next     = bad_in_reg;
        p_next          = p_reg;
        rest_next       = rest_reg;
        e_next          = e_reg;
        m_next          = m_reg;
        k_next          = k_reg;
        tp_next         = tp_reg;
        bad_next        = bad_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        t1_next         = t1_reg;
        sv_we           = 1'b0;
        sv_waddr        = m_reg[AW-1:0];
        sv_wdata        = {n_reg, k_reg};
        sv_raddr        = n_reg;
        tr_we           = 1'b0;
        cf_we           = 1'b0;
        mul_a           = '0;
        mul_b           = '0;

        if (cfg_valid) begin
            last_index_next = cfg_last_index;
        end
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                sv_we    = 1'b1;
                sv_waddr = clr_reg;
                sv_wdata = '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    out_index_next = s_index;
                    out_coef_next  = '0;
                    n_next         = AW'(s_index);
                    ap_next        = s_trace_value;
                    bad_in_next    = s_bad_prime;
                    if (reject) begin
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_REJ;
                    end else begin
                        expected_next = s_index + IDX_W'(1);
                        if (overflow_reg) begin
                            out_valid_next  = 1'b1;
                            out_status_next = STAT_OVF;
                        end else begin
                            state_next = ST_LOOKUP;
                        end
                    end
                end
            end
            ST_LOOKUP: begin
                sv_raddr   = n_reg;
                state_next = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                e_next = EW'(1);
                mul_a  = COEF_W'(n_reg);
                mul_b  = COEF_W'(n_reg);
                if (sf_rd == '0) begin
                    // New prime: record it, then mark its multiples from n*n.
                    sv_we      = 1'b1;
                    sv_waddr   = n_reg;
                    sv_wdata   = {n_reg, AW'(1)};
                    tr_we      = 1'b1;
                    p_next     = n_reg;
                    rest_next  = AW'(1);
                    k_next     = n_reg;
                    state_next = ST_SQUARE;
                end else begin
                    p_next     = sf_rd;
                    rest_next  = q_rd;
                    state_next = ST_FACT_RD;
                end
            end
            ST_SQUARE: begin
                m_next = prod[AW:0];
                if (prod < PROD_W'(MAX_N)) begin
                    state_next = ST_MARK_RD;
                end else begin
                    state_next = ST_POWER_INIT;
                end
            end
            ST_MARK_RD: begin
                sv_raddr   = m_reg[AW-1:0];
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                sv_we  = (sf_rd == '0);
                m_next = m_step;
                k_next = k_reg + AW'(1);
                if (32'(m_step) >= 32'(MAX_N)) begin
                    state_next = ST_POWER_INIT;
                end else begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_FACT_RD: begin
                sv_raddr   = rest_reg;
                state_next = ST_FACT_CHK;
            end
            ST_FACT_CHK: begin
                // Strip one more factor p while the sieve still names it.
                if (sf_rd == p_reg) begin
                    rest_next  = q_rd;
                    e_next     = e_reg + EW'(1);
                    state_next = ST_FACT_RD;
                end else begin
                    state_next = ST_POWER_INIT;
                end
            end
            ST_POWER_INIT: begin
                tp_next   = $signed(tr_rdata[TRACE_W-1:0]);
                bad_next  = tr_rdata[TW-1];
                cur_next  = COEF_W'($signed(tr_rdata[TRACE_W-1:0]));
                prev_next = COEF_W'(1);
                if (e_reg == EW'(1)) begin
                    state_next = ST_FINAL_A;
                end else begin
                    state_next = ST_PW_A;
                end
            end
            ST_PW_A: begin
                mul_a      = COEF_W'(tp_reg);
                mul_b      = cur_reg;
                state_next = ST_PW_B;
            end
            ST_PW_B: begin
                mul_a   = COEF_W'(p_reg);
                mul_b   = prev_reg;
                t1_next = prod;
                if (bad_reg) begin
                    // Bad prime: plain power of the trace.
                    if (!fits32(prod)) begin
                        overflow_next   = 1'b1;
                        out_valid_next  = 1'b1;
                        out_status_next = STAT_OVF;
                        state_next      = ST_IDLE;
                    end else begin
                        cur_next = prod[COEF_W-1:0];
                        e_next   = e_reg - EW'(1);
                        if (e_reg == EW'(2)) begin
                            state_next = ST_FINAL_A;
                        end else begin
                            state_next = ST_PW_A;
                        end
                    end
                end else begin
                    state_next = ST_PW_C;
                end
            end
            ST_PW_C: begin
                // Good prime: a_p*cur - p*prev.
                if (!fits32(diff)) begin
                    overflow_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = STAT_OVF;
                    state_next      = ST_IDLE;
                end else begin
                    prev_next = cur_reg;
                    cur_next  = diff[COEF_W-1:0];
                    e_next    = e_reg - EW'(1);
                    if (e_reg == EW'(2)) begin
                        state_next = ST_FINAL_A;
                    end else begin
                        state_next = ST_PW_A;
                    end
                end
            end
            ST_FINAL_A: begin
                mul_a      = rest_coef;
                mul_b      = cur_reg;
                state_next = ST_FINAL_B;
            end
            ST_FINAL_B: begin
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
                if (fits32(prod)) begin
                    cf_we           = 1'b1;
                    out_coef_next   = prod[COEF_W-1:0];
                    out_status_next = STAT_OK;
                end else begin
                    overflow_next   = 1'b1;
                    out_status_next = STAT_OVF;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            last_index_reg <= IDX_W'(4095);
            expected_reg   <= IDX_W'(2);
            overflow_reg   <= 1'b0;
            clr_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            last_index_reg <= last_index_next;
            expected_reg   <= expected_next;
            overflow_reg   <= overflow_next;
            clr_reg        <= clr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        out_index_reg  <= out_index_next;
        out_coef_reg   <= out_coef_next;
        out_status_reg <= out_status_next;
        n_reg          <= n_next;
        ap_reg         <= ap_next;
        bad_in_reg     <= bad_in_next;
        p_reg          <= p_next;
        rest_reg       <= rest_next;
        e_reg          <= e_next;
        m_reg          <= m_next;
        k_reg          <= k_next;
        tp_reg         <= tp_next;
        bad_reg        <= bad_next;
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        t1_reg         <= t1_next;
    end

endmodule
`default_nettype wire

>>> src/epcg_checker.sv
`default_nettype none
module epcg_checker
    import epcg_pkg::*;
(
    input wire logic                      aclk,
    input wire logic                      aresetn,
    input wire logic                      s_ready,
    input wire logic                      m_valid,
    input wire logic                      m_ready,
    input wire logic [IDX_W-1:0]          m_out_index,
    input wire logic signed [COEF_W-1:0]  m_coefficient,
    input wire logic [STAT_W-1:0]         m_status
);

    // No beat is offered in the cycle after reset.
    assert property (@(posedge aclk) $past(!aresetn) |-> !m_valid)
        else $error("result beat right after reset");

    // A failing status always carries a zero coefficient.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_coefficient == '0))
        else $error("nonzero coefficient with failing status");

    // No new index is taken while a result is pending.
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready)
        else $error("input ready with result pending");

    // A stalled result beat holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_out_index) &&
                                   $stable(m_coefficient) && $stable(m_status)))
        else $error("stalled result beat changed");

endmodule

bind euler_product_coefficient_generator_unit epcg_checker u_epcg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_index   (m_out_index),
    .m_coefficient (m_coefficient),
    .m_status      (m_status)
);
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
    import epcg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SIEVE_N = MAX_N_DEF;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [COEF_W-1:0] coef;
        logic [STAT_W-1:0]        st;
    } coef_beat_t;

    // Tracks the Euler-product state and queues the coefficient each index must produce.
    class coef_tracker;
        int unsigned              smallest_div[SIEVE_N];
        longint                   prime_trace[SIEVE_N];
        bit                       prime_bad[SIEVE_N];
        longint                   coef_memo[SIEVE_N];
        int unsigned              next_idx;
        int unsigned              limit;
        bit                       overflowed;
        coef_beat_t               pending[$];
        int                       errors;
        int                       n_ok;
        int                       n_ovf;
        int                       n_rej;

        function new();
            foreach (smallest_div[i]) begin
                smallest_div[i] = 0;
                coef_memo[i] = 0;
            end
            coef_memo[1] = 1;
            next_idx = 2;
            limit = 4095;
            overflowed = 0;
            errors = 0;
            n_ok = 0;
            n_ovf = 0;
            n_rej = 0;
        endfunction

        function bit in_range32(longint v);
            return v >= -64'sd2147483648 && v <= 64'sd2147483647;
        endfunction

        // Computes a_n for an accepted input beat and queues it.
        function void note_index(logic [IDX_W-1:0] n, logic signed [TRACE_W-1:0] tv, logic bp);
            coef_beat_t r;
            int unsigned p, rest, e, m;
            longint tp, prv, cur, pw, nxt, val;
            bit over;
            r.idx = n;
            r.coef = 0;
            r.st = STAT_OK;
            over = 0;
            if (n != next_idx || n > limit || n < 2) begin
                r.st = STAT_REJ;
            end else begin
                next_idx = n + 1;
                if (overflowed) begin
                    r.st = STAT_OVF;
                end else begin
                    // A new prime records its trace and marks its multiples.
                    if (smallest_div[n] == 0) begin
                        smallest_div[n] = n;
                        prime_trace[n] = tv;
                        prime_bad[n] = bp;
                        for (m = n * n; m < SIEVE_N; m += n)
                            if (smallest_div[m] == 0) smallest_div[m] = n;
                    end
                    p = smallest_div[n];
                    rest = n;
                    e = 0;
                    while (rest % p == 0) begin
                        rest = rest / p;
                        e++;
                    end
                    // Prime-power chain, stopping at the first term out of range.
                    tp = prime_trace[p];
                    prv = 1;
                    cur = tp;
                    pw = tp;
                    for (int k = 2; k <= e && !over; k++) begin
                        if (prime_bad[p]) begin
                            pw = pw * tp;
                        end else begin
                            nxt = tp * cur - longint'(p) * prv;
                            prv = cur;
                            cur = nxt;
                            pw = cur;
                        end
                        if (!in_range32(pw)) over = 1;
                    end
                    if (!over) begin
                        val = coef_memo[rest] * pw;
                        if (!in_range32(val)) over = 1;
                        else begin
                            coef_memo[n] = val;
                            r.coef = val[COEF_W-1:0];
                        end
                    end
                    if (over) begin
                        overflowed = 1;
                        r.st = STAT_OVF;
                    end
                end
            end
            case (r.st)
                STAT_OK:  n_ok++;
                STAT_OVF: n_ovf++;
                default:  n_rej++;
            endcase
            pending.push_back(r);
        endfunction

        // Compares one output beat with the oldest queued coefficient.
        function void check_beat(logic [IDX_W-1:0] idx, logic signed [COEF_W-1:0] coef,
                                 logic [STAT_W-1:0] st);
            coef_beat_t w;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat index %0d coefficient %0d status %0d",
                         $time, idx, coef, st);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (idx !== w.idx) begin
                $display("%0t: index expected %0d actual %0d", $time, w.idx, idx);
                errors++;
            end
            if (coef !== w.coef) begin
                $display("%0t: coefficient of %0d expected %0d actual %0d",
                         $time, w.idx, w.coef, coef);
                errors++;
            end
            if (st !== w.st) begin
                $display("%0t: status of %0d expected %0d actual %0d", $time, w.idx, w.st, st);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_last_index;
    logic                      s_valid;
    logic                      s_ready;
    logic [IDX_W-1:0]          s_index;
    logic signed [TRACE_W-1:0] s_trace_value;
    logic                      s_bad_prime;
    logic                      m_valid;
    logic                      m_ready;
    logic [IDX_W-1:0]          m_out_index;
    logic signed [COEF_W-1:0]  m_coefficient;
    logic [STAT_W-1:0]         m_status;

    coef_tracker tracker = new();
    bit          gaps_on = 1;
    int          stall_left = 0;

    euler_product_coefficient_generator_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_last_index(cfg_last_index),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_index       (s_index),
        .s_trace_value (s_trace_value),
        .s_bad_prime   (s_bad_prime),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_index   (m_out_index),
        .m_coefficient (m_coefficient),
        .m_status      (m_status)
    );

    // Clock.
    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #4_000_000;
        $display("tb failed");
        $finish;
    end

    // Result side: check each beat and stall in random bursts.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_beat(m_out_index, m_coefficient, m_status);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 6);
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // Sends one input beat, with an optional idle burst ahead of it.
    task automatic send_index(input logic [IDX_W-1:0] n, input logic signed [TRACE_W-1:0] tv,
                              input logic bp);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1;
        s_index <= n;
        s_trace_value <= tv;
        s_bad_prime <= bp;
        do @(posedge aclk); while (!s_ready);
        tracker.note_index(n, tv, bp);
    endtask

    // Holds the input side until every queued coefficient has come out.
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (tracker.pending.size() != 0) @(posedge aclk);
    endtask

    // Writes the index bound; only called while no index is in flight.
    task automatic write_limit(input logic [IDX_W-1:0] v);
        cfg_valid <= 1;
        cfg_last_index <= v;
        do @(posedge aclk); while (!cfg_ready);
        tracker.limit = 32'(v);
        cfg_valid <= 0;
    endtask

    initial begin
        logic [IDX_W-1:0]          n;
        logic signed [TRACE_W-1:0] tv;
        aresetn = 0;
        cfg_valid = 0;
        cfg_last_index = 0;
        s_valid = 0;
        s_index = 0;
        s_trace_value = 0;
        s_bad_prime = 0;
        m_ready = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        write_limit(12'd4095);

        // Directed: rejected indices, a bad prime at full trace, powers and zero traces.
        send_index(12'd5, 9'sd0, 1'b0);
        send_index(12'd0, 9'sd0, 1'b0);
        send_index(12'd1, -9'sd1, 1'b1);
        send_index(12'd4095, 9'sd128, 1'b0);
        send_index(12'd2, 9'sd1, 1'b0);
        send_index(12'd2, 9'sd1, 1'b0);
        send_index(12'd3, 9'sd128, 1'b1);
        send_index(12'd4, -9'sd128, 1'b1);
        send_index(12'd5, -9'sd2, 1'b0);
        send_index(12'd6, 9'sd0, 1'b0);
        send_index(12'd7, -9'sd1, 1'b1);
        send_index(12'd8, 9'sd5, 1'b0);
        send_index(12'd9, 9'sd0, 1'b0);
        send_index(12'd10, 9'sd0, 1'b0);
        send_index(12'd11, -9'sd128, 1'b0);
        send_index(12'd12, 9'sd3, 1'b0);
        send_index(12'd13, 9'sd0, 1'b0);
        send_index(12'd14, 9'sd0, 1'b0);

        // Random: mostly the next index in order, some out-of-order noise.
        for (int i = 0; i < 400; i++) begin
            if (i == 100) begin
                drain();
                write_limit(IDX_W'(tracker.next_idx + 4));
            end else if (i == 130) begin
                drain();
                write_limit(12'd2);
            end else if (i == 140) begin
                drain();
                write_limit(12'd4095);
            end else if (i == 340) begin
                gaps_on = 0;
            end
            if ($urandom_range(0, 6) != 0) n = IDX_W'(tracker.next_idx);
            else if ($urandom_range(0, 1) == 0) n = IDX_W'($urandom_range(0, 4095));
            else n = IDX_W'(tracker.next_idx + $urandom_range(0, 2) - 1);
            if (n > 50 && $urandom_range(0, 19) == 0) tv = TRACE_W'($urandom_range(0, 256) - 128);
            else tv = TRACE_W'($urandom_range(0, 12) - 6);
            send_index(n, tv, $urandom_range(0, 5) == 0);
        end

        drain();
        repeat (40) @(posedge aclk);
        $display("Covered %0d coefficients, %0d overflow beats and %0d rejected indices,",
                 tracker.n_ok, tracker.n_ovf, tracker.n_rej);
        $display("with index bounds 4095, 2 and a narrow window, under random stalls.");
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
